FILE: design/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge while reset is released.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/rcpu_pkg.sv
package rcpu_pkg;

    localparam int FIELD_BITS   = 16;
    localparam int MAX_LANES    = 8;
    localparam int CFG_BITS     = 13;
    localparam int CFG_IDX_BITS = 3;
    localparam int Q_DEPTH      = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_CROP_START_X = 3'd0,
        REG_CROP_START_Y = 3'd1,
        REG_CROP_WIDTH   = 3'd2,
        REG_CROP_HEIGHT  = 3'd3,
        REG_IMAGE_WIDTH  = 3'd4,
        REG_IMAGE_HEIGHT = 3'd5
    } t_cfg_reg;

    localparam logic [CFG_BITS-1:0] RST_CROP_START_X = 13'd0;
    localparam logic [CFG_BITS-1:0] RST_CROP_START_Y = 13'd0;
    localparam logic [CFG_BITS-1:0] RST_CROP_WIDTH   = 13'd640;
    localparam logic [CFG_BITS-1:0] RST_CROP_HEIGHT  = 13'd480;
    localparam logic [CFG_BITS-1:0] RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [CFG_BITS-1:0] RST_IMAGE_HEIGHT = 13'd480;

    typedef struct packed {
        logic [FIELD_BITS-1:0] pixel_0;
        logic [FIELD_BITS-1:0] pixel_1;
        logic [FIELD_BITS-1:0] pixel_2;
        logic [FIELD_BITS-1:0] pixel_3;
        logic [FIELD_BITS-1:0] pixel_4;
        logic [FIELD_BITS-1:0] pixel_5;
        logic [FIELD_BITS-1:0] pixel_6;
        logic [FIELD_BITS-1:0] pixel_7;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_BITS-1:0] pixel_out;
        logic                  last_in_packet;
    } t_out_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

FILE: design/rcpu_front.sv
module rcpu_front #(
    parameter int PIXELS_PER_PACKET = 8,
    parameter int PIXEL_BITS        = 16,
    parameter int COORD_BITS        = 12
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_cfg_valid,
    output logic                                              o_cfg_ready,
    input  logic [rcpu_pkg::CFG_IDX_BITS-1:0]                 i_cfg_index,
    input  logic [rcpu_pkg::CFG_BITS-1:0]                     i_cfg_data,
    input  logic                                              i_in_valid,
    output logic                                              o_in_stall,
    input  rcpu_pkg::t_in_item                                i_in_data,
    input  rcpu_pkg::t_q_status                               i_q_status,
    output logic                                              o_push,
    output logic [PIXELS_PER_PACKET-1:0][PIXEL_BITS-1:0]      o_push_pix,
    output logic [PIXELS_PER_PACKET-1:0]                      o_push_mask
);
    import rcpu_pkg::*;

    localparam int SW = ((COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS) + 1;

    logic [CFG_BITS-1:0] r_crop_start_x;
    logic [CFG_BITS-1:0] r_crop_start_y;
    logic [CFG_BITS-1:0] r_crop_width;
    logic [CFG_BITS-1:0] r_crop_height;
    logic [CFG_BITS-1:0] r_image_width;
    logic [CFG_BITS-1:0] r_image_height;

    logic [COORD_BITS-1:0] r_col;
    logic [COORD_BITS-1:0] r_row;
    logic [COORD_BITS-1:0] n_col;
    logic [COORD_BITS-1:0] n_row;

    logic [MAX_LANES-1:0][FIELD_BITS-1:0] w_lanes;
    logic [SW-1:0] w_end_x;
    logic [SW-1:0] w_end_y;
    logic [SW-1:0] w_next_col;
    logic [SW-1:0] w_next_row;
    logic          w_row_ok;
    logic          w_accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_q_status.full;
    assign w_accept    = i_in_valid && !i_q_status.full;

    assign w_lanes[0] = i_in_data.pixel_0;
    assign w_lanes[1] = i_in_data.pixel_1;
    assign w_lanes[2] = i_in_data.pixel_2;
    assign w_lanes[3] = i_in_data.pixel_3;
    assign w_lanes[4] = i_in_data.pixel_4;
    assign w_lanes[5] = i_in_data.pixel_5;
    assign w_lanes[6] = i_in_data.pixel_6;
    assign w_lanes[7] = i_in_data.pixel_7;

    assign w_end_x  = SW'(r_crop_start_x) + SW'(r_crop_width);
    assign w_end_y  = SW'(r_crop_start_y) + SW'(r_crop_height);
    assign w_row_ok = (SW'(r_row) >= SW'(r_crop_start_y)) && (SW'(r_row) < w_end_y);

    always_comb begin
        logic [SW-1:0] lane_x;
        for (int j = 0; j < PIXELS_PER_PACKET; j++) begin
            lane_x         = SW'(r_col) + SW'(j);
            o_push_mask[j] = w_row_ok && (lane_x >= SW'(r_crop_start_x)) && (lane_x < w_end_x);
            o_push_pix[j]  = w_lanes[j][PIXEL_BITS-1:0];
        end
    end

    assign o_push = w_accept && (o_push_mask != '0);

    assign w_next_col = SW'(r_col) + SW'(PIXELS_PER_PACKET);
    assign w_next_row = SW'(r_row) + SW'(1);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_accept) begin
            if (w_next_col >= SW'(r_image_width)) begin
                n_col = '0;
                n_row = (w_next_row >= SW'(r_image_height)) ? '0 : w_next_row[COORD_BITS-1:0];
            end else begin
                n_col = w_next_col[COORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col          <= '0;
            r_row          <= '0;
            r_crop_start_x <= RST_CROP_START_X;
            r_crop_start_y <= RST_CROP_START_Y;
            r_crop_width   <= RST_CROP_WIDTH;
            r_crop_height  <= RST_CROP_HEIGHT;
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_CROP_START_X: r_crop_start_x <= i_cfg_data;
                    REG_CROP_START_Y: r_crop_start_y <= i_cfg_data;
                    REG_CROP_WIDTH:   r_crop_width   <= i_cfg_data;
                    REG_CROP_HEIGHT:  r_crop_height  <= i_cfg_data;
                    REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                    REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

FILE: design/rcpu_fifo.sv
module rcpu_fifo #(
    parameter int WIDTH = 136
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [WIDTH-1:0]     i_data,
    input  logic                 i_pop,
    output logic [WIDTH-1:0]     o_data,
    output rcpu_pkg::t_q_status  o_status
);
    import rcpu_pkg::*;
    `include "assert_macros.svh"

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_status.full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_data         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    `ASSERT_RST(a_no_push_when_full, i_clk, i_rst_n, i_push |-> !o_status.full, "request written into a full queue")
    `ASSERT_RST(a_no_pop_when_empty, i_clk, i_rst_n, i_pop |-> !o_status.empty, "request taken from an empty queue")
    `ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, i_push && !i_pop, !o_status.empty, "queue empty after a write")

endmodule

FILE: design/rcpu_back.sv
module rcpu_back #(
    parameter int PIXELS_PER_PACKET = 8,
    parameter int PIXEL_BITS        = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  rcpu_pkg::t_q_status                           i_q_status,
    input  logic [PIXELS_PER_PACKET-1:0][PIXEL_BITS-1:0]  i_head_pix,
    input  logic [PIXELS_PER_PACKET-1:0]                  i_head_mask,
    output logic                                          o_pop,
    output logic                                          o_out_valid,
    input  logic                                          i_out_stall,
    output rcpu_pkg::t_out_item                           o_out_data
);
    import rcpu_pkg::*;
    `include "assert_macros.svh"

    logic [PIXELS_PER_PACKET-1:0] r_done;
    logic                         r_out_valid;
    t_out_item                    r_out;

    logic [PIXELS_PER_PACKET-1:0] w_rem;
    logic [PIXELS_PER_PACKET-1:0] w_pick;
    logic [PIXELS_PER_PACKET-1:0] w_left;
    logic [PIXEL_BITS-1:0]        w_pix;
    logic                         w_can;
    logic                         w_emit;

    assign w_rem  = i_head_mask & ~r_done;
    assign w_pick = w_rem & (~w_rem + PIXELS_PER_PACKET'(1));
    assign w_left = w_rem & ~w_pick;
    assign w_can  = !r_out_valid || !i_out_stall;
    assign w_emit = !i_q_status.empty && w_can;
    assign o_pop  = w_emit && (w_left == '0);

    always_comb begin
        w_pix = '0;
        for (int j = 0; j < PIXELS_PER_PACKET; j++) begin
            w_pix = w_pix | (i_head_pix[j] & {PIXEL_BITS{w_pick[j]}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out.pixel_out      <= FIELD_BITS'(w_pix);
            r_out.last_in_packet <= (w_left == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_done      <= '0;
        end else begin
            if (w_can) begin
                r_out_valid <= w_emit;
            end
            if (w_emit) begin
                r_done <= o_pop ? '0 : (r_done | w_pick);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ASSERT_RST(a_done_within_mask, i_clk, i_rst_n, !i_q_status.empty |-> ((r_done & ~i_head_mask) == '0), "lane marked sent outside the packet mask")
    `ASSERT_RST(a_pick_onehot, i_clk, i_rst_n, w_emit |-> $onehot(w_pick), "no single lane chosen for a pixel")

endmodule

FILE: design/roi_crop_packet_unpacker.sv
// Path: an accepted request is written into the queue; the back end then registers its
// first cropped pixel in the output stage. The back end sends one pixel a cycle while
// the output is not stalled and holds each request until its cropped pixels are sent;
// one with no cropped pixel is not queued. A two-entry queue lets intake run ahead.
// Reset (synchronous, active low) restores the register defaults, sets the position
// to the top left corner and empties the queue and the output stage.
module roi_crop_packet_unpacker #(
    parameter int PIXELS_PER_PACKET = 8,
    parameter int PIXEL_BITS        = 16,
    parameter int COORD_BITS        = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rcpu_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [rcpu_pkg::CFG_BITS-1:0]     i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  rcpu_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output rcpu_pkg::t_out_item               o_out_data
);
    import rcpu_pkg::*;

    localparam int ENTRY_W = PIXELS_PER_PACKET * PIXEL_BITS + PIXELS_PER_PACKET;

    t_q_status                                    w_q_status;
    logic                                         w_push;
    logic                                         w_pop;
    logic [PIXELS_PER_PACKET-1:0][PIXEL_BITS-1:0] w_push_pix;
    logic [PIXELS_PER_PACKET-1:0]                 w_push_mask;
    logic [PIXELS_PER_PACKET-1:0][PIXEL_BITS-1:0] w_head_pix;
    logic [PIXELS_PER_PACKET-1:0]                 w_head_mask;

    rcpu_front #(
        .PIXELS_PER_PACKET (PIXELS_PER_PACKET),
        .PIXEL_BITS        (PIXEL_BITS),
        .COORD_BITS        (COORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_push_pix  (w_push_pix),
        .o_push_mask (w_push_mask)
    );

    rcpu_fifo #(
        .WIDTH (ENTRY_W)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   ({w_push_pix, w_push_mask}),
        .i_pop    (w_pop),
        .o_data   ({w_head_pix, w_head_mask}),
        .o_status (w_q_status)
    );

    rcpu_back #(
        .PIXELS_PER_PACKET (PIXELS_PER_PACKET),
        .PIXEL_BITS        (PIXEL_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (w_q_status),
        .i_head_pix  (w_head_pix),
        .i_head_mask (w_head_mask),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
